[rtl/wnvam_pkg.sv]
package wnvam_pkg;

    localparam int NUM_NOTES  = 48;
    localparam int ADDR_W     = $clog2(NUM_NOTES);
    localparam int SCORE_W    = 32;
    localparam int TIME_W     = 32;
    localparam int NOTE_W     = 16;
    localparam int LEVEL_W    = 16;
    localparam int PNOTE_W    = 7;
    localparam int BEST_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Scores are kept in signed Q24.8 units
    localparam logic signed [SCORE_W-1:0] BONUS_Q8  = SCORE_W'(2560);
    localparam logic signed [SCORE_W-1:0] BASE_Q8   = SCORE_W'(25600);
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_START = 2'd0,
        CFG_WIN_STOP  = 2'd1,
        CFG_PRES_NOTE = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic accept;
        logic wr_frag;
        logic wr_seed;
        logic scan_rd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic first;
        logic last;
        logic hit;
        logic seed_need;
        logic scan_end;
    } t_stat;

endpackage

[rtl/wnvam_ctrl.sv]
module wnvam_ctrl
    import wnvam_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_UPD   = 6'b000010,
        ST_SEED  = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.wr_frag = i_stat.hit;
                if (i_stat.seed_need) begin
                    n_state = ST_SEED;
                end else if (i_stat.last) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SEED: begin
                cmd.wr_seed = 1'b1;
                n_state     = i_stat.last ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (!r_out_vld || i_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_valid = r_out_vld;
    assign o_cmd   = cmd;

endmodule

[rtl/wnvam_dp.sv]
module wnvam_dp
    import wnvam_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [TIME_W-1:0]           i_frag_time,
    input  logic signed [NOTE_W-1:0]    i_frag_note,
    input  logic signed [LEVEL_W-1:0]   i_frag_level,
    input  logic                        i_first_item,
    input  logic                        i_last_item,
    input  t_cmd                        i_cmd,
    output t_stat                       o_stat,
    output logic [BEST_W-1:0]           o_best_note
);

    // configuration
    logic [TIME_W-1:0]  r_win_start;
    logic [TIME_W-1:0]  r_win_stop;
    logic [PNOTE_W-1:0] r_pnote;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= '0;
            r_win_stop  <= '0;
            r_pnote     <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIN_START: r_win_start <= i_cfg_data[TIME_W-1:0];
                CFG_WIN_STOP:  r_win_stop  <= i_cfg_data[TIME_W-1:0];
                CFG_PRES_NOTE: r_pnote     <= i_cfg_data[PNOTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic              pres_in;
    logic [ADDR_W-1:0] pres_addr;

    assign pres_in   = !r_pnote[PNOTE_W-1] && (int'(r_pnote[PNOTE_W-2:0]) < NUM_NOTES);
    assign pres_addr = ADDR_W'(r_pnote[PNOTE_W-2:0]);

    // round the Q8.8 note to nearest, halves away from zero
    logic              note_neg;
    logic [NOTE_W:0]   note_mag;
    logic [NOTE_W:0]   note_sum;
    logic [8:0]        note_rnd;
    logic              note_in;
    logic              in_win;
    logic [ADDR_W-1:0] in_addr;

    assign note_neg = i_frag_note[NOTE_W-1];
    assign note_mag = note_neg ? (NOTE_W+1)'(-{i_frag_note[NOTE_W-1], i_frag_note})
                               : {1'b0, i_frag_note};
    assign note_sum = note_mag + (NOTE_W+1)'(128);
    assign note_rnd = 9'(note_sum >> 8);
    assign note_in  = (int'(note_rnd) < NUM_NOTES) && (!note_neg || (note_rnd == 9'd0));
    assign in_win   = (i_frag_time >= r_win_start) && (i_frag_time <= r_win_stop);
    assign in_addr  = note_rnd[ADDR_W-1:0];

    // item registers
    logic                      r_first;
    logic                      r_last;
    logic                      r_hit;
    logic                      r_seed_same;
    logic                      r_seed_need;
    logic [ADDR_W-1:0]         r_addr;
    logic signed [LEVEL_W-1:0] r_level;
    logic                      hit;
    logic                      seed_same;

    assign hit       = in_win && note_in;
    assign seed_same = i_first_item && pres_in && hit && (in_addr == pres_addr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_first     <= i_first_item;
            r_last      <= i_last_item;
            r_hit       <= hit;
            r_seed_same <= seed_same;
            r_seed_need <= i_first_item && pres_in && !seed_same;
            r_addr      <= in_addr;
            r_level     <= i_frag_level;
        end
    end

    // score store
    logic signed [SCORE_W-1:0] mem [NUM_NOTES];
    logic [NUM_NOTES-1:0]      r_valid;
    logic signed [SCORE_W-1:0] r_rdata;
    logic                      r_rd_vld;
    logic [ADDR_W-1:0]         r_scan;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic                      wr_en;
    logic signed [SCORE_W-1:0] wr_data;
    logic signed [SCORE_W-1:0] rd_score;

    assign rd_addr  = i_cmd.scan_rd ? r_scan : in_addr;
    assign wr_en    = i_cmd.wr_frag || i_cmd.wr_seed;
    assign wr_addr  = i_cmd.wr_frag ? r_addr : pres_addr;
    assign rd_score = r_rd_vld ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata  <= mem[rd_addr];
        r_rd_vld <= r_valid[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.accept && i_first_item) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // fragment update with saturation
    logic signed [SCORE_W-1:0] old_score;
    logic signed [SCORE_W+1:0] sum;
    logic signed [SCORE_W-1:0] sat;

    always_comb begin
        if (r_first) begin
            old_score = r_seed_same ? BONUS_Q8 : '0;
        end else begin
            old_score = rd_score;
        end
        sum = (SCORE_W+2)'(old_score) + (SCORE_W+2)'(BASE_Q8) + (SCORE_W+2)'(r_level);
        if (sum > (SCORE_W+2)'(SCORE_MAX)) begin
            sat = SCORE_MAX;
        end else if (sum < (SCORE_W+2)'(SCORE_MIN)) begin
            sat = SCORE_MIN;
        end else begin
            sat = SCORE_W'(sum);
        end
    end

    assign wr_data = i_cmd.wr_frag ? sat : BONUS_Q8;

    // argmax scan over bins 1..NUM_NOTES-1
    logic                      r_cmp_vld;
    logic                      r_cmp_first;
    logic [ADDR_W-1:0]         r_cmp_idx;
    logic signed [SCORE_W-1:0] r_best_score;
    logic [ADDR_W-1:0]         r_best_idx;
    logic [ADDR_W-1:0]         r_best_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_scan <= ADDR_W'(1);
        end else if (i_cmd.scan_rd) begin
            r_scan <= r_scan + ADDR_W'(1);
        end
        r_cmp_first <= (r_scan == ADDR_W'(1));
        r_cmp_idx   <= r_scan;
        // strict compare keeps the lowest index on ties
        if (r_cmp_vld && (r_cmp_first || (rd_score > r_best_score))) begin
            r_best_score <= rd_score;
            r_best_idx   <= r_cmp_idx;
        end
        if (i_cmd.load_out) begin
            r_best_out <= r_best_idx;
        end
    end

    assign o_best_note = BEST_W'(r_best_out);

    always_comb begin
        o_stat           = '0;
        o_stat.first     = r_first;
        o_stat.last      = r_last;
        o_stat.hit       = r_hit;
        o_stat.seed_need = r_seed_need;
        o_stat.scan_end  = (r_scan == ADDR_W'(NUM_NOTES - 1));
    end

endmodule

[rtl/windowed_note_vote_argmax_core.sv]
// A fragment passes through accept and score update, and a first item also seeds the
// bonus bin when it needs to. A last item adds a scan of NUM_NOTES-1 bins, one per
// cycle through the single read port of the score store, then the drain and done
// states; done holds the result until the output register frees up. A new fragment is
// taken only when the last one is done, limited by the read-modify-write on one bin.
// Reset (synchronous, active low) restores the control, configuration and valid registers and marks all scores zero.
module windowed_note_vote_argmax_core
    import wnvam_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [TIME_W-1:0]         i_frag_time,
    input  logic signed [NOTE_W-1:0]  i_frag_note,
    input  logic signed [LEVEL_W-1:0] i_frag_level,
    input  logic                      i_first_item,
    input  logic                      i_last_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [BEST_W-1:0]         o_best_note
);

    t_cmd  cmd;
    t_stat stat;

    wnvam_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    wnvam_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_frag_time  (i_frag_time),
        .i_frag_note  (i_frag_note),
        .i_frag_level (i_frag_level),
        .i_first_item (i_first_item),
        .i_last_item  (i_last_item),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_best_note  (o_best_note)
    );

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr_frag && cmd.wr_seed))
        else $error("fragment and seed writes collide");

    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_rd |-> !o_ready)
        else $error("item accepted during scan");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_valid)
        else $error("loaded result not shown");

    a_bin_zero_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_best_note != '0))
        else $error("bin zero reported");

endmodule

[tb/note_vote_checker.sv]
`timescale 1ns / 1ps

module note_vote_checker
    import wnvam_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [TIME_W-1:0]         i_frag_time,
    input  logic signed [NOTE_W-1:0]  i_frag_note,
    input  logic signed [LEVEL_W-1:0] i_frag_level,
    input  logic                      i_first_item,
    input  logic                      i_last_item,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [BEST_W-1:0]         i_best_note,
    output int                        o_mismatches,
    output int                        o_outstanding
);

    logic [TIME_W-1:0]         win_start;
    logic [TIME_W-1:0]         win_stop;
    logic signed [PNOTE_W-1:0] sung_note;
    logic signed [SCORE_W-1:0] vote_bins [NUM_NOTES];
    logic [BEST_W-1:0]         best_note_q [$];
    int                        mismatch_cnt = 0;
    int                        pending_cnt = 0;

    assign o_mismatches  = mismatch_cnt;
    assign o_outstanding = pending_cnt;

    function automatic int nearest_note(logic signed [NOTE_W-1:0] q8);
        int x;
        x = int'(q8);
        if (x >= 0)
            return (x + 128) / 256;
        return -((-x + 128) / 256);
    endfunction

    function automatic logic signed [SCORE_W-1:0] clamp_score(longint sum);
        if (sum > longint'(SCORE_MAX))
            return SCORE_MAX;
        if (sum < longint'(SCORE_MIN))
            return SCORE_MIN;
        return SCORE_W'(sum);
    endfunction

    function automatic logic [BEST_W-1:0] winning_note();
        int best;
        best = 1;
        // bin 0 votes but is never reported; strict compare keeps the lowest index
        for (int i = 2; i < NUM_NOTES; i++) begin
            if (vote_bins[i] > vote_bins[best])
                best = i;
        end
        return BEST_W'(best);
    endfunction

    task automatic tally_fragment();
        int n;
        if (i_first_item) begin
            for (int i = 0; i < NUM_NOTES; i++)
                vote_bins[i] = '0;
            if (sung_note >= 0 && sung_note < NUM_NOTES)
                vote_bins[sung_note] = BONUS_Q8;
        end
        if (i_frag_time >= win_start && i_frag_time <= win_stop) begin
            n = nearest_note(i_frag_note);
            if (n >= 0 && n < NUM_NOTES)
                vote_bins[n] = clamp_score(longint'(vote_bins[n]) + longint'(BASE_Q8)
                                           + longint'(i_frag_level));
        end
        if (i_last_item)
            best_note_q.insert(best_note_q.size(), winning_note());
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_start = '0;
            win_stop  = '0;
            sung_note = '1;
            for (int i = 0; i < NUM_NOTES; i++)
                vote_bins[i] = '0;
            best_note_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIN_START: win_start = i_cfg_data[TIME_W-1:0];
                    CFG_WIN_STOP:  win_stop  = i_cfg_data[TIME_W-1:0];
                    CFG_PRES_NOTE: sung_note = i_cfg_data[PNOTE_W-1:0];
                    default: ;
                endcase
            end
            // retire the result before queueing anything for this edge's item
            if (i_out_valid && i_out_ready) begin
                if (best_note_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected result best_note=%0d", $time, i_best_note);
                end else if (best_note_q[0] !== i_best_note) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: best_note expected %0d got %0d",
                                 $time, best_note_q[0], i_best_note);
                    void'(best_note_q.pop_front());
                end else begin
                    void'(best_note_q.pop_front());
                end
            end
            if (i_in_valid && i_in_ready)
                tally_fragment();
        end
        pending_cnt = best_note_q.size();
    end

endmodule

[tb/windowed_note_vote_argmax_core_tb.sv]
`timescale 1ns / 1ps

module windowed_note_vote_argmax_core_tb;
    import wnvam_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int NUM_PHASES   = 14;
    localparam int PHASE_ITEMS  = 78;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [TIME_W-1:0]         i_frag_time = '0;
    logic signed [NOTE_W-1:0]  i_frag_note = '0;
    logic signed [LEVEL_W-1:0] i_frag_level = '0;
    logic                      i_first_item = 1'b0;
    logic                      i_last_item = 1'b0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [BEST_W-1:0]         o_best_note;

    int          mismatch_cnt;
    int          outstanding;
    int          sent_cnt = 0;
    int          ready_hold = 0;
    logic        quiet = 1'b0;
    logic [31:0] win_lo = '0;
    logic [31:0] win_hi = '0;

    windowed_note_vote_argmax_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_frag_time  (i_frag_time),
        .i_frag_note  (i_frag_note),
        .i_frag_level (i_frag_level),
        .i_first_item (i_first_item),
        .i_last_item  (i_last_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_best_note  (o_best_note)
    );

    note_vote_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_frag_time   (i_frag_time),
        .i_frag_note   (i_frag_note),
        .i_frag_level  (i_frag_level),
        .i_first_item  (i_first_item),
        .i_last_item   (i_last_item),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_best_note   (o_best_note),
        .o_mismatches  (mismatch_cnt),
        .o_outstanding (outstanding)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (quiet || $urandom_range(0, 2) != 0) begin
            i_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 8);
        end else begin
            i_ready    <= 1'b0;
            ready_hold <= idle_len();
        end
    end

    // Called right after a rising edge; returns at the edge that takes the item.
    task automatic push_frag(input logic [TIME_W-1:0] t, input logic [NOTE_W-1:0] note,
                             input logic [LEVEL_W-1:0] level, input logic is_first,
                             input logic is_last);
        int gap;
        gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_frag_time  <= t;
        i_frag_note  <= note;
        i_frag_level <= level;
        i_first_item <= is_first;
        i_last_item  <= is_last;
        do @(posedge i_clk); while (!o_ready);
        sent_cnt++;
    endtask

    // Drop valid and wait until every result is out and the block has gone quiet.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [31:0] start, input logic [31:0] stop,
                             input logic [31:0] pnote_word);
        settle();
        win_lo     = start;
        win_hi     = stop;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIN_START;
        i_cfg_data <= start;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_WIN_STOP;
        i_cfg_data <= stop;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PRES_NOTE;
        i_cfg_data <= pnote_word;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_time();
        int     r;
        longint span;
        r = $urandom_range(0, 99);
        if (r < 10)
            return win_lo;
        if (r < 20)
            return win_hi;
        if (r < 25)
            return win_lo - 1;
        if (r < 30)
            return win_hi + 1;
        if (r < 75 && win_lo <= win_hi) begin
            span = longint'(win_hi) - longint'(win_lo) + 1;
            return win_lo + 32'(longint'($urandom) % span);
        end
        return $urandom;
    endfunction

    function automatic logic [NOTE_W-1:0] pick_note();
        int r;
        int n;
        int off;
        r   = $urandom_range(0, 99);
        n   = int'($urandom_range(0, 49)) - 1;
        off = int'($urandom_range(0, 255)) - 128;
        if (r < 65)
            return NOTE_W'(n * 256 + off);
        if (r < 80) begin
            // land right on or next to the half-way points
            case ($urandom_range(0, 3))
                0: off = -128;
                1: off = -127;
                2: off = 127;
                default: off = 128;
            endcase
            return NOTE_W'(n * 256 + off);
        end
        return NOTE_W'($urandom);
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return LEVEL_W'($urandom);
        if (r < 70)
            return LEVEL_W'($urandom_range(0, 511));
        if (r < 85)
            return '0;
        return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    endfunction

    function automatic logic [31:0] pick_pnote_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0: w[PNOTE_W-1:0] = 7'h7F;
            1: w[PNOTE_W-1:0] = 7'd0;
            2: w[PNOTE_W-1:0] = 7'd47;
            3: w[PNOTE_W-1:0] = 7'd48;
            4: w[PNOTE_W-1:0] = 7'd63;
            5: w[PNOTE_W-1:0] = 7'h40;
            6: w[PNOTE_W-1:0] = PNOTE_W'($urandom_range(0, 47));
            default: w[PNOTE_W-1:0] = PNOTE_W'($urandom);
        endcase
        return w;
    endfunction

    task automatic run_query();
        int   len;
        int   kind;
        logic is_first;
        logic is_last;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        kind = $urandom_range(0, 19);
        for (int k = 0; k < len; k++) begin
            // kind 0: query without an opening item, kind 1: random markers
            is_first = (k == 0) && (kind != 0);
            is_last  = (k == len - 1);
            if (kind == 1) begin
                is_first = 1'($urandom_range(0, 1));
                is_last  = 1'($urandom_range(0, 1));
            end
            push_frag(pick_time(), pick_note(), pick_level(), is_first, is_last);
        end
    endtask

    initial begin
        logic [31:0] start;
        logic [31:0] stop;
        logic [31:0] span;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // rounding edges, window edges, level extremes
        load_regs(32'h0001_0000, 32'h0005_0000, 32'd47);
        push_frag(32'h0001_0000, 16'h0A80, 16'h0000, 1'b1, 1'b0);
        push_frag(32'h0005_0000, 16'h0A7F, 16'h7FFF, 1'b0, 1'b0);
        push_frag(32'h0000_FFFF, 16'h1400, 16'h7FFF, 1'b0, 1'b0);
        push_frag(32'h0005_0001, 16'h1400, 16'h7FFF, 1'b0, 1'b0);
        push_frag(32'h0003_0000, 16'hFF80, 16'h7FFF, 1'b0, 1'b0);
        push_frag(32'h0003_0000, 16'hFF81, 16'h7FFF, 1'b0, 1'b0);
        push_frag(32'h0003_0000, 16'h2F7F, 16'h8000, 1'b0, 1'b0);
        push_frag(32'h0003_0000, 16'h2F80, 16'h7FFF, 1'b0, 1'b0);
        push_frag(32'h0003_0000, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
        push_frag(32'h0003_0000, 16'h8000, 16'h7FFF, 1'b0, 1'b0);
        push_frag(32'h0003_0000, 16'h0100, 16'h8000, 1'b0, 1'b0);
        push_frag(32'h0002_0000, 16'h0AFF, 16'h8000, 1'b0, 1'b1);
        // single-item query, then a tie between bins 3 and 7
        push_frag(32'h0002_0000, 16'h0300, 16'h0000, 1'b1, 1'b1);
        push_frag(32'h0002_0000, 16'h0700, 16'h0005, 1'b1, 1'b0);
        push_frag(32'h0002_0000, 16'h0300, 16'h0005, 1'b0, 1'b0);
        push_frag(32'h0002_0000, 16'h0000, 16'h7FFF, 1'b0, 1'b1);
        // no opening item: add on top of the previous query
        push_frag(32'h0002_0000, 16'h0700, 16'h0010, 1'b0, 1'b1);
        push_frag(32'h0002_0000, 16'h3000, 16'h0000, 1'b1, 1'b1);

        // inverted window, bonus in bin 0
        load_regs(32'h0000_0005, 32'h0000_0004, 32'h0000_0000);
        push_frag(32'h0000_0004, 16'h0500, 16'h0100, 1'b1, 1'b1);
        push_frag(32'h0000_0005, 16'h0500, 16'h0100, 1'b1, 1'b1);

        // present note far out of range, upper data bits set
        load_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFC0);
        push_frag(32'hFFFF_FFFF, 16'h3000, 16'h7FFF, 1'b1, 1'b1);
        load_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_003F);
        push_frag(32'h0000_0000, 16'hFF00, 16'h7FFF, 1'b1, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 7)
                0: begin
                    start = '0;
                    stop  = '1;
                end
                1: begin
                    start = '1;
                    stop  = '1;
                end
                2: begin
                    start = '0;
                    stop  = '0;
                end
                3: begin
                    stop  = $urandom_range(0, 32'h7FFF_FFFF);
                    start = stop + 1 + $urandom_range(0, 1000);
                end
                default: begin
                    start = $urandom;
                    span  = $urandom_range(0, 32'h0020_0000);
                    stop  = (start > ~span) ? 32'hFFFF_FFFF : start + span;
                end
            endcase
            load_regs(start, stop, pick_pnote_word());
            quiet <= (p % 5 == 4);
            sent_cnt = 0;
            while (sent_cnt < PHASE_ITEMS)
                run_query();
        end

        settle();
        if (mismatch_cnt == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/wnvam_pkg.sv
rtl/wnvam_ctrl.sv
rtl/wnvam_dp.sv
rtl/windowed_note_vote_argmax_core.sv
tb/note_vote_checker.sv
tb/windowed_note_vote_argmax_core_tb.sv
